/* rtl/bilinear_upscale_4x_assert.svh */
// assertion macros for the 4x bilinear upscaler checker
// expects clk_i and rst_ni in the scope of use
`ifndef BILINEAR_UPSCALE_4X_ASSERT_SVH
`define BILINEAR_UPSCALE_4X_ASSERT_SVH

// same-cycle implication
`define BU4_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bu4 check failed");

// next-cycle implication
`define BU4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bu4 check failed");

`endif

/* rtl/bu4_pkg.sv */
// shared types and constants of the 4x bilinear upscaler
// no dependencies
`timescale 1ns / 1ps

package bu4_pkg;

  localparam int IN_SIZE = 128;
  localparam int IDX_W   = $clog2(IN_SIZE);
  localparam int PIX_W   = 8;
  localparam int COORD_W = 9;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COORD_W-1:0] coord_t;

  // 5x5 interpolated block and 8x8 block with border extrapolation
  typedef pix_t [0:4][0:4] grid5_t;
  typedef pix_t [0:7][0:7] grid8_t;

  // 4x4 output blocks of one source pixel, in emission order
  typedef enum logic [1:0] {
    BLK_MAIN   = 2'd0,
    BLK_RIGHT  = 2'd1,
    BLK_BOTTOM = 2'd2,
    BLK_CORNER = 2'd3
  } blk_e;

endpackage

/* rtl/bu4_if.sv */
// stream interfaces of the 4x bilinear upscaler: source pixels and results
// depends on bu4_pkg
`timescale 1ns / 1ps

interface bu4_pix_if;
  logic          valid;
  logic          ready;
  bu4_pkg::pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bu4_res_if;
  logic            valid;
  logic            ready;
  bu4_pkg::coord_t out_row;
  bu4_pkg::coord_t out_col;
  bu4_pkg::pix_t   value;
  logic            last_of_run;

  modport source (output valid, output out_row, output out_col, output value,
                  output last_of_run, input ready);
  modport sink (input valid, input out_row, input out_col, input value,
                input last_of_run, output ready);
endinterface

/* rtl/bu4_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read returns the old contents on a same-address write
`timescale 1ns / 1ps

module bu4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bilinear_upscale_4x.sv */
// 4x bilinear upscaler: a pixel passes stage 0, stage 1, stage 2 and the output
// register before its first result. each pixel with row and column above zero
// yields 16 results, 32 on the last column or row, 64 on the last pixel; the output
// register gives one result per cycle while res_o.ready is high. the line memory
// holds the row above; reset clears position, neighbors and pipeline, the line
// memory is not cleared since each entry is written before its contents are used.
`timescale 1ns / 1ps

module bilinear_upscale_4x (
  input  logic                clk_i,
  input  logic                rst_ni,
  bu4_pix_if.sink             pix_i,
  bu4_res_if.source           res_o
);

  // floor average of two pixels
  function automatic bu4_pkg::pix_t avg2(bu4_pkg::pix_t a, bu4_pkg::pix_t b);
    logic [bu4_pkg::PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[bu4_pkg::PIX_W:1];
  endfunction

  // mirrored extrapolation 2*edge - inner, clamped to pixel range
  function automatic bu4_pkg::pix_t extrap(bu4_pkg::pix_t e, bu4_pkg::pix_t in);
    logic signed [bu4_pkg::PIX_W+1:0] t;
    t = $signed({1'b0, e, 1'b0}) - $signed({2'b00, in});
    if (t < 0) begin
      return '0;
    end else if (t > 255) begin
      return '1;
    end
    return t[bu4_pkg::PIX_W-1:0];
  endfunction

  // raster position of the next pixel and left neighbors
  bu4_pkg::idx_t row_q, row_d, col_q, col_d;
  bu4_pkg::pix_t left_px_q, left_above_q;

  // stage 0: line memory read in flight
  logic          s0_valid_q, s0_valid_d;
  bu4_pkg::pix_t s0_px_q;
  bu4_pkg::idx_t s0_row_q, s0_col_q;

  // stage 1: interpolated 5x5 block
  logic             s1_valid_q, s1_valid_d;
  bu4_pkg::grid5_t  s1_g_q, s1_g_d;
  logic             s1_lr_q, s1_lc_q;
  bu4_pkg::idx_t    s1_rb_q, s1_cb_q;

  // stage 2: 8x8 block being emitted
  logic             s2_valid_q, s2_valid_d;
  bu4_pkg::grid8_t  s2_g_q, s2_g_d;
  logic             s2_lr_q, s2_lc_q;
  bu4_pkg::idx_t    s2_rb_q, s2_cb_q;
  bu4_pkg::blk_e    blk_q, blk_d, blk_nxt;
  logic [3:0]       pos_q;

  // output register
  logic             res_valid_q, res_valid_d;
  bu4_pkg::coord_t  res_row_q, res_col_q;
  bu4_pkg::pix_t    res_val_q;
  logic             res_last_q;

  logic          in_acc, s0_prod, s0_go, s0_lr, s0_lc, s2_load;
  logic          out_free, emit, blk_done, blk_end, fin;
  bu4_pkg::pix_t above;
  logic [2:0]    g_ri, g_ci;

  // line memory of the source row above
  bu4_ram #(
    .WIDTH (bu4_pkg::PIX_W),
    .DEPTH (bu4_pkg::IN_SIZE)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (col_q),
    .wdata_i (pix_i.pixel),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (above)
  );

  // pipeline handshake
  assign in_acc   = pix_i.valid && pix_i.ready;
  assign s0_prod  = (s0_row_q != '0) && (s0_col_q != '0);
  assign s0_lr    = s0_row_q == bu4_pkg::IDX_W'(bu4_pkg::IN_SIZE - 1);
  assign s0_lc    = s0_col_q == bu4_pkg::IDX_W'(bu4_pkg::IN_SIZE - 1);
  assign out_free = !res_valid_q || res_o.ready;
  assign emit     = s2_valid_q && out_free;
  assign fin      = blk_done && blk_end;
  assign s2_load  = s1_valid_q && (!s2_valid_q || (emit && fin));
  assign s0_go    = s0_valid_q && (!s0_prod || !s1_valid_q || s2_load);
  assign pix_i.ready = !s0_valid_q || s0_go;

  // raster position advance
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_q == bu4_pkg::IDX_W'(bu4_pkg::IN_SIZE - 1)) begin
        col_d = '0;
        row_d = (row_q == bu4_pkg::IDX_W'(bu4_pkg::IN_SIZE - 1)) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // 5x5 interpolation from the four corner pixels
  always_comb begin
    s1_g_d = '0;
    s1_g_d[0][0] = left_above_q;
    s1_g_d[0][4] = above;
    s1_g_d[4][0] = left_px_q;
    s1_g_d[4][4] = s0_px_q;
    for (int i = 0; i <= 4; i += 4) begin
      s1_g_d[i][2] = avg2(s1_g_d[i][0], s1_g_d[i][4]);
      s1_g_d[i][1] = avg2(s1_g_d[i][0], s1_g_d[i][2]);
      s1_g_d[i][3] = avg2(s1_g_d[i][2], s1_g_d[i][4]);
    end
    s1_g_d[2][0] = avg2(s1_g_d[0][0], s1_g_d[4][0]);
    s1_g_d[2][2] = avg2(s1_g_d[0][2], s1_g_d[4][2]);
    s1_g_d[2][4] = avg2(s1_g_d[0][4], s1_g_d[4][4]);
    s1_g_d[2][1] = avg2(s1_g_d[2][0], s1_g_d[2][2]);
    s1_g_d[2][3] = avg2(s1_g_d[2][2], s1_g_d[2][4]);
    for (int j = 0; j <= 4; j++) begin
      s1_g_d[1][j] = avg2(s1_g_d[0][j], s1_g_d[2][j]);
      s1_g_d[3][j] = avg2(s1_g_d[2][j], s1_g_d[4][j]);
    end
  end

  // border extrapolation: rows first, then columns of all eight rows
  always_comb begin
    s2_g_d = '0;
    for (int i = 0; i <= 4; i++) begin
      for (int j = 0; j <= 4; j++) begin
        s2_g_d[i][j] = s1_g_q[i][j];
      end
    end
    for (int k = 1; k <= 3; k++) begin
      for (int j = 0; j <= 4; j++) begin
        s2_g_d[4+k][j] = extrap(s1_g_q[4][j], s1_g_q[4-k][j]);
      end
    end
    for (int i = 0; i < 8; i++) begin
      for (int k = 1; k <= 3; k++) begin
        s2_g_d[i][4+k] = extrap(s2_g_d[i][4], s2_g_d[i][4-k]);
      end
    end
  end

  // block sequencing: main, right, bottom, corner as the borders call for
  always_comb begin
    blk_nxt = bu4_pkg::BLK_MAIN;
    blk_end = 1'b1;
    case (blk_q)
      bu4_pkg::BLK_MAIN: begin
        if (s2_lc_q) begin
          blk_nxt = bu4_pkg::BLK_RIGHT;
          blk_end = 1'b0;
        end else if (s2_lr_q) begin
          blk_nxt = bu4_pkg::BLK_BOTTOM;
          blk_end = 1'b0;
        end
      end
      bu4_pkg::BLK_RIGHT: begin
        if (s2_lr_q) begin
          blk_nxt = bu4_pkg::BLK_BOTTOM;
          blk_end = 1'b0;
        end
      end
      bu4_pkg::BLK_BOTTOM: begin
        if (s2_lc_q) begin
          blk_nxt = bu4_pkg::BLK_CORNER;
          blk_end = 1'b0;
        end
      end
      default: begin
        blk_nxt = bu4_pkg::BLK_MAIN;
        blk_end = 1'b1;
      end
    endcase
  end

  assign blk_done = pos_q == 4'hf;
  assign blk_d    = blk_done ? blk_nxt : blk_q;
  assign g_ri     = {blk_q[1], pos_q[3:2]};
  assign g_ci     = {blk_q[0], pos_q[1:0]};

  // stage valid bits
  always_comb begin
    s0_valid_d = s0_valid_q;
    if (in_acc) begin
      s0_valid_d = 1'b1;
    end else if (s0_go) begin
      s0_valid_d = 1'b0;
    end
    s1_valid_d = s1_valid_q;
    if (s0_go && s0_prod) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (emit && fin) begin
      s2_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= '0;
      col_q        <= '0;
      left_px_q    <= '0;
      left_above_q <= '0;
      s0_valid_q   <= 1'b0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      blk_q        <= bu4_pkg::BLK_MAIN;
      pos_q        <= '0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      s0_valid_q  <= s0_valid_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      res_valid_q <= res_valid_d;
      if (s0_go) begin
        left_px_q    <= s0_px_q;
        left_above_q <= above;
      end
      if (s2_load) begin
        blk_q <= bu4_pkg::BLK_MAIN;
        pos_q <= '0;
      end else if (emit) begin
        blk_q <= blk_d;
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_px_q  <= pix_i.pixel;
      s0_row_q <= row_q;
      s0_col_q <= col_q;
    end
    if (s0_go && s0_prod) begin
      s1_g_q  <= s1_g_d;
      s1_lr_q <= s0_lr;
      s1_lc_q <= s0_lc;
      s1_rb_q <= s0_row_q - 1'b1;
      s1_cb_q <= s0_col_q - 1'b1;
    end
    if (s2_load) begin
      s2_g_q  <= s2_g_d;
      s2_lr_q <= s1_lr_q;
      s2_lc_q <= s1_lc_q;
      s2_rb_q <= s1_rb_q;
      s2_cb_q <= s1_cb_q;
    end
    if (emit) begin
      res_row_q  <= bu4_pkg::COORD_W'({s2_rb_q, 2'b00} + {{(bu4_pkg::IDX_W-1){1'b0}}, g_ri});
      res_col_q  <= bu4_pkg::COORD_W'({s2_cb_q, 2'b00} + {{(bu4_pkg::IDX_W-1){1'b0}}, g_ci});
      res_val_q  <= s2_g_q[g_ri][g_ci];
      res_last_q <= fin;
    end
  end

  // result channel
  assign res_o.valid       = res_valid_q;
  assign res_o.out_row     = res_row_q;
  assign res_o.out_col     = res_col_q;
  assign res_o.value       = res_val_q;
  assign res_o.last_of_run = res_last_q;

endmodule

/* rtl/bu4_checker.sv */
// port-level checks of the 4x bilinear upscaler, bound to the top level
// depends on bu4_pkg and bilinear_upscale_4x_assert.svh
`timescale 1ns / 1ps
`include "bilinear_upscale_4x_assert.svh"

module bu4_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input bu4_pkg::coord_t out_row_i,
  input bu4_pkg::coord_t out_col_i,
  input bu4_pkg::pix_t   value_i,
  input logic            out_last_i
);

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  // stalled result holds
  `BU4_ASSERT_NEXT(a_res_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_row_i) && $stable(out_col_i) && $stable(value_i) && $stable(out_last_i))

  // a run ends on the bottom-right pixel of a 4x4 block
  `BU4_ASSERT_IMPL(a_last_corner, out_valid_i && out_last_i, (out_row_i[1:0] == 2'd3) && (out_col_i[1:0] == 2'd3))

  // within a block row the next result follows at once, one column on
  `BU4_ASSERT_NEXT(a_col_step, out_acc && !out_last_i && (out_col_i[1:0] != 2'd3), out_valid_i && (out_col_i == $past(out_col_i) + 9'd1) && (out_row_i == $past(out_row_i)))

  // end of a block row moves to the next row of the same block
  `BU4_ASSERT_NEXT(a_row_step, out_acc && !out_last_i && (out_col_i[1:0] == 2'd3) && (out_row_i[1:0] != 2'd3), out_valid_i && (out_row_i == $past(out_row_i) + 9'd1) && (out_col_i == $past(out_col_i) - 9'd3))

endmodule

bind bilinear_upscale_4x bu4_checker u_bu4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_row_i   (res_o.out_row),
  .out_col_i   (res_o.out_col),
  .value_i     (res_o.value),
  .out_last_i  (res_o.last_of_run)
);
